>>> rtl/core/fea_pkg.sv
// Shared types and codes for the free extent allocator.
// No dependencies; every other file of the block depends on this package.
package fea_pkg;

    typedef enum logic [1:0] {
        OP_AT   = 2'd0,
        OP_LOW  = 2'd1,
        OP_HIGH = 2'd2,
        OP_FREE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOFIT  = 2'd1,
        ST_FULL   = 2'd2,
        ST_DOUBLE = 2'd3
    } status_t;

    // Per-cell evaluation results handed to the selection logic.
    typedef struct packed {
        logic ok;        // allocation can be carved here
        logic ff;        // fits, but the split needs a free entry
        logic at_start;  // candidate starts at the extent start
        logic at_end;    // candidate ends at the extent end
        logic dbl;       // freed range overlaps this extent
        logic down;      // freed range ends where this extent starts
        logic up;        // freed range starts where this extent ends
        logic brk;       // extent starts above the freed start address
    } cell_flags_t;

    // Table update applied to the chain.
    typedef struct packed {
        logic rm;   // remove entry t, upper entries shift down
        logic ins;  // insert at p, upper entries shift up
        logic md;   // rewrite entry t
    } cell_cmd_t;

endpackage

>>> rtl/core/fea_req_if.sv
// Request channel of the free extent allocator: valid/ready plus payload.
// Depends on fea_pkg for the operation code type.
interface fea_req_if #(
    parameter int AW = 48
);
    logic              valid;
    logic              ready;
    fea_pkg::op_t      op;
    logic [AW-1:0]     start_address;
    logic [AW-1:0]     length;
    logic [AW-1:0]     alignment;

    modport source (output valid, op, start_address, length, alignment, input ready);
    modport sink   (input valid, op, start_address, length, alignment, output ready);
endinterface

>>> rtl/core/fea_rsp_if.sv
// Response channel of the free extent allocator: valid/ready plus payload.
// Depends on fea_pkg for the status code type.
interface fea_rsp_if #(
    parameter int AW = 48
);
    logic              valid;
    logic              ready;
    logic [AW-1:0]     address;
    fea_pkg::status_t  status;

    modport source (output valid, address, status, input ready);
    modport sink   (input valid, address, status, output ready);
endinterface

>>> rtl/core/fea_cell.sv
// One entry of the sorted extent chain: holds start/length, evaluates a
// request against them and shifts to or from its neighbors. Uses fea_pkg.
module fea_cell #(
    parameter int AW  = 48,
    parameter int CW  = 6,
    parameter int IW  = 5,
    parameter int IDX = 0
) (
    input  logic                 clk,
    input  logic                 cand_en,
    input  logic                 eval_en,
    input  logic                 apply_en,
    input  fea_pkg::op_t         op,
    input  logic [AW-1:0]        s,
    input  logic [AW-1:0]        size,
    input  logic [AW-1:0]        am1,
    input  logic [AW:0]          fe,
    input  logic                 full,
    input  logic [CW-1:0]        count,
    input  fea_pkg::cell_cmd_t   cmd,
    input  logic [IW-1:0]        t,
    input  logic [IW-1:0]        p,
    input  logic [AW-1:0]        mod_start,
    input  logic [AW-1:0]        mod_len,
    input  logic [AW-1:0]        ins_start,
    input  logic [AW-1:0]        ins_len,
    input  logic [AW-1:0]        left_start,
    input  logic [AW-1:0]        left_len,
    input  logic [AW-1:0]        right_start,
    input  logic [AW-1:0]        right_len,
    output logic [AW-1:0]        start,
    output logic [AW-1:0]        len,
    output logic [AW:0]          cand,
    output logic [AW:0]          rem,
    output fea_pkg::cell_flags_t flags
);
    import fea_pkg::*;

    logic [AW-1:0] start_reg, start_next;
    logic [AW-1:0] len_reg, len_next;
    logic [AW:0]   ee_reg, ee_next;
    logic [AW:0]   cand_reg, cand_next;
    logic          skip_reg, skip_next;
    logic [AW:0]   rem_reg, rem_next;
    cell_flags_t   flags_reg, flags_next;

    logic          valid;
    logic [AW:0]   es_w;
    logic [AW:0]   sz_w;
    logic [AW:0]   am1_w;
    logic          fit;
    logic          split;
    logic          nz;
    logic [IW-1:0] me;

    assign valid = count > CW'(IDX);
    assign es_w  = {1'b0, start_reg};
    assign sz_w  = {1'b0, size};
    assign am1_w = {1'b0, am1};
    assign me    = IW'(IDX);

    // Candidate address and extent end.
    always_comb
    begin
        ee_next   = es_w + {1'b0, len_reg};
        skip_next = 1'b0;
        case (op)
            OP_AT:   cand_next = {1'b0, s};
            OP_LOW:  cand_next = (es_w + am1_w) & ~am1_w;
            OP_HIGH:
            begin
                skip_next = sz_w > ee_next;
                cand_next = (ee_next - sz_w) & ~am1_w;
            end
            default: cand_next = {1'b0, s};
        endcase
    end

    // Fit test and free-range checks.
    always_comb
    begin
        rem_next = ee_reg - cand_reg;
        fit      = valid && !skip_reg && (cand_reg >= es_w) && (cand_reg <= ee_reg)
                   && (sz_w <= rem_next);
        split    = (cand_reg != es_w) && (sz_w != rem_next);
        nz       = size != '0;
        flags_next.ok       = fit && !(nz && split && full);
        flags_next.ff       = fit && nz && split && full;
        flags_next.at_start = cand_reg == es_w;
        flags_next.at_end   = sz_w == rem_next;
        flags_next.dbl      = valid && (es_w < fe) && ({1'b0, s} < ee_reg);
        flags_next.down     = valid && (es_w == fe);
        flags_next.up       = valid && (ee_reg == {1'b0, s});
        flags_next.brk      = valid && (start_reg > s);
    end

    // Table update: shift, load or hold.
    always_comb
    begin
        start_next = start_reg;
        len_next   = len_reg;
        if (cmd.rm && me >= t)
        begin
            start_next = right_start;
            len_next   = right_len;
        end
        else if (cmd.ins && me > p)
        begin
            start_next = left_start;
            len_next   = left_len;
        end
        else if (cmd.ins && me == p)
        begin
            start_next = ins_start;
            len_next   = ins_len;
        end
        else if (cmd.md && me == t)
        begin
            start_next = mod_start;
            len_next   = mod_len;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cand_en)
        begin
            ee_reg   <= ee_next;
            cand_reg <= cand_next;
            skip_reg <= skip_next;
        end
        if (eval_en)
        begin
            rem_reg   <= rem_next;
            flags_reg <= flags_next;
        end
        if (apply_en)
        begin
            start_reg <= start_next;
            len_reg   <= len_next;
        end
    end

    assign start = start_reg;
    assign len   = len_reg;
    assign cand  = cand_reg;
    assign rem   = rem_reg;
    assign flags = flags_reg;

endmodule

>>> rtl/core/free_extent_allocator_top.sv
// Free extent allocator top: sequencer, selection logic and the cell chain.
// Depends on fea_pkg, fea_req_if, fea_rsp_if and fea_cell.
//
// Usage: requests arrive on req (op, start_address, length, alignment) and
// each yields exactly one response on rsp (address, status). A transaction
// is taken when valid and ready are both high. ops: alloc at address, alloc
// lowest aligned up, alloc highest aligned down, free.
// Flow: an accepted request steps through the candidate, evaluate, select and
// apply states; the cells do candidate, evaluate and apply in parallel and the
// top does the select. One request is in flight at a time and req.ready returns
// only in the idle cycle after apply, so a new request waits until the last is
// through; the select stage's priority pick over all cells sets the cycle time.
// Reset empties the table (extent count zero); no clearing pass is needed.
// Stall: a response waits in the output register until rsp.ready; the next
// request is still accepted, but its apply step holds until the output
// register frees up, so the table and the responses stay in order.
module free_extent_allocator_top #(
    parameter int MAX_EXTENTS = 32,
    parameter int ADDR_BITS   = 48
) (
    input  logic   clk,
    input  logic   rst_n,
    fea_req_if.sink   req,
    fea_rsp_if.source rsp
);
    import fea_pkg::*;

    localparam int AW = ADDR_BITS;
    localparam int CW = $clog2(MAX_EXTENTS + 1);
    localparam int IW = $clog2(MAX_EXTENTS);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CAND  = 5'b00010,
        S_EVAL  = 5'b00100,
        S_SEL   = 5'b01000,
        S_APPLY = 5'b10000
    } state_t;

    state_t         state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    op_t            op_reg;
    logic [AW-1:0]  s_reg, size_reg, am1_reg;
    logic [AW:0]    fe_reg;

    cell_cmd_t      cmd_reg, cmd_next;
    logic [IW-1:0]  t_reg, t_next, p_reg, p_next;
    logic [AW-1:0]  mod_start_reg, mod_start_next, mod_len_reg, mod_len_next;
    logic [AW-1:0]  ins_start_reg, ins_start_next, ins_len_reg, ins_len_next;
    logic [AW-1:0]  res_addr_reg, res_addr_next;
    status_t        res_st_reg, res_st_next;

    logic           out_valid_reg, out_valid_next;
    logic [AW-1:0]  out_addr_reg;
    status_t        out_st_reg;

    logic [AW-1:0]  c_start [MAX_EXTENTS];
    logic [AW-1:0]  c_len   [MAX_EXTENTS];
    logic [AW:0]    c_cand  [MAX_EXTENTS];
    logic [AW:0]    c_rem   [MAX_EXTENTS];
    cell_flags_t    c_flags [MAX_EXTENTS];

    logic           accept;
    logic           go;
    logic           full;

    assign accept    = req.valid && req.ready;
    assign req.ready = state_reg == S_IDLE;
    assign go        = !out_valid_reg || rsp.ready;
    assign full      = count_reg == CW'(MAX_EXTENTS);

    genvar gi;
    generate
        for (gi = 0; gi < MAX_EXTENTS; gi++)
        begin : g_cell
            localparam int LI = (gi == 0) ? 0 : gi - 1;
            localparam int RI = (gi == MAX_EXTENTS - 1) ? gi : gi + 1;
            fea_cell #(.AW(AW), .CW(CW), .IW(IW), .IDX(gi)) u_cell (
                .clk        (clk),
                .cand_en    (state_reg == S_CAND),
                .eval_en    (state_reg == S_EVAL),
                .apply_en   (state_reg == S_APPLY && go),
                .op         (op_reg),
                .s          (s_reg),
                .size       (size_reg),
                .am1        (am1_reg),
                .fe         (fe_reg),
                .full       (full),
                .count      (count_reg),
                .cmd        (cmd_reg),
                .t          (t_reg),
                .p          (p_reg),
                .mod_start  (mod_start_reg),
                .mod_len    (mod_len_reg),
                .ins_start  (ins_start_reg),
                .ins_len    (ins_len_reg),
                .left_start (c_start[LI]),
                .left_len   (c_len[LI]),
                .right_start(c_start[RI]),
                .right_len  (c_len[RI]),
                .start      (c_start[gi]),
                .len        (c_len[gi]),
                .cand       (c_cand[gi]),
                .rem        (c_rem[gi]),
                .flags      (c_flags[gi])
            );
        end
    endgenerate

    // Priority pick over the chain and build the table update.
    logic          found, any_ff, any_dbl;
    logic [IW-1:0] sel_idx;
    logic [AW-1:0] sel_start, sel_len;
    logic [AW:0]   sel_cand, sel_rem;
    cell_flags_t   sel_flags;
    logic          hit;
    logic [AW:0]   cand_end;
    logic [AW:0]   rem_left;

    always_comb
    begin
        found     = 1'b0;
        any_ff    = 1'b0;
        any_dbl   = 1'b0;
        sel_idx   = '0;
        sel_start = '0;
        sel_len   = '0;
        sel_cand  = '0;
        sel_rem   = '0;
        sel_flags = '0;
        for (int i = 0; i < MAX_EXTENTS; i++)
        begin
            any_ff  = any_ff | c_flags[i].ff;
            any_dbl = any_dbl | c_flags[i].dbl;
        end
        for (int j = 0; j < MAX_EXTENTS; j++)
        begin
            int k;
            k = (op_reg == OP_HIGH) ? MAX_EXTENTS - 1 - j : j;
            hit = (op_reg == OP_FREE)
                  ? (c_flags[k].down | c_flags[k].up | c_flags[k].brk)
                  : c_flags[k].ok;
            if (!found && hit)
            begin
                found     = 1'b1;
                sel_idx   = IW'(k);
                sel_start = c_start[k];
                sel_len   = c_len[k];
                sel_cand  = c_cand[k];
                sel_rem   = c_rem[k];
                sel_flags = c_flags[k];
            end
        end
    end

    always_comb
    begin
        cand_end       = sel_cand + {1'b0, size_reg};
        rem_left       = sel_rem - {1'b0, size_reg};
        cmd_next       = '0;
        t_next         = sel_idx;
        p_next         = sel_idx + IW'(1);
        mod_start_next = sel_start;
        mod_len_next   = AW'(sel_cand - {1'b0, sel_start});
        ins_start_next = cand_end[AW-1:0];
        ins_len_next   = rem_left[AW-1:0];
        res_addr_next  = '0;
        res_st_next    = ST_NOFIT;
        if (op_reg != OP_FREE)
        begin
            if (found)
            begin
                res_addr_next = sel_cand[AW-1:0];
                res_st_next   = ST_OK;
                if (size_reg != '0)
                begin
                    if (sel_flags.at_start && sel_flags.at_end)
                    begin
                        cmd_next.rm = 1'b1;
                    end
                    else if (sel_flags.at_start)
                    begin
                        cmd_next.md    = 1'b1;
                        mod_start_next = cand_end[AW-1:0];
                        mod_len_next   = rem_left[AW-1:0];
                    end
                    else if (sel_flags.at_end)
                    begin
                        cmd_next.md = 1'b1;
                    end
                    else
                    begin
                        cmd_next.md  = 1'b1;
                        cmd_next.ins = 1'b1;
                    end
                end
            end
            else if (any_ff)
            begin
                res_st_next = ST_FULL;
            end
        end
        else
        begin
            ins_start_next = s_reg;
            ins_len_next   = size_reg;
            mod_len_next   = sel_len + size_reg;
            if (fe_reg[AW])
            begin
                res_st_next = ST_NOFIT;
            end
            else if (size_reg == '0)
            begin
                res_st_next = ST_OK;
            end
            else if (any_dbl)
            begin
                res_st_next = ST_DOUBLE;
            end
            else if (found && sel_flags.down)
            begin
                res_st_next    = ST_OK;
                cmd_next.md    = 1'b1;
                mod_start_next = s_reg;
            end
            else if (found && sel_flags.up)
            begin
                res_st_next = ST_OK;
                cmd_next.md = 1'b1;
            end
            else if (full)
            begin
                res_st_next = ST_FULL;
            end
            else
            begin
                res_st_next  = ST_OK;
                cmd_next.ins = 1'b1;
                p_next       = found ? sel_idx : count_reg[IW-1:0];
            end
        end
    end

    // Sequencer, extent count and output register.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:  if (accept) state_next = S_CAND;
            S_CAND:  state_next = S_EVAL;
            S_EVAL:  state_next = S_SEL;
            S_SEL:   state_next = S_APPLY;
            S_APPLY:
            begin
                if (go)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    if (cmd_reg.rm)
                    begin
                        count_next = count_reg - CW'(1);
                    end
                    else if (cmd_reg.ins)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= req.op;
            s_reg    <= req.start_address;
            size_reg <= req.length;
            am1_reg  <= (req.alignment == '0) ? '0 : req.alignment - AW'(1);
            fe_reg   <= {1'b0, req.start_address} + {1'b0, req.length};
        end
        if (state_reg == S_SEL)
        begin
            cmd_reg       <= cmd_next;
            t_reg         <= t_next;
            p_reg         <= p_next;
            mod_start_reg <= mod_start_next;
            mod_len_reg   <= mod_len_next;
            ins_start_reg <= ins_start_next;
            ins_len_reg   <= ins_len_next;
            res_addr_reg  <= res_addr_next;
            res_st_reg    <= res_st_next;
        end
        if (state_reg == S_APPLY && go)
        begin
            out_addr_reg <= res_addr_reg;
            out_st_reg   <= res_st_reg;
        end
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.address = out_addr_reg;
    assign rsp.status  = out_st_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_EXTENTS))
        else $error("extent count beyond table size");

    a_count_only_on_apply: assert property (@(posedge clk) disable iff (!rst_n)
        !(state_reg == S_APPLY && go) |=> $stable(count_reg))
        else $error("extent count changed outside apply");

    a_no_grow_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPLY && go && full) |-> !cmd_reg.ins)
        else $error("insert issued with a full table");

    a_fail_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != ST_OK) |-> rsp.address == '0)
        else $error("failed transaction carries an address");

endmodule
